[design/rsvs_pkg.sv]
// Shared types, widths and codes for the regression split variance score block.
package rsvs_pkg;

  // Configuration of the block
  localparam int MAX_SIDE_SAMPLES = 4096;
  localparam int VALUE_BITS       = 16;

  // Fixed field widths of the transactions
  localparam int TARGET_W = 16;
  localparam int SCORE_W  = 45;
  localparam int ERR_W    = 2;

  // Derived accumulator widths
  localparam int CNT_W  = $clog2(MAX_SIDE_SAMPLES + 1);
  localparam int SUM_W  = VALUE_BITS + $clog2(MAX_SIDE_SAMPLES);
  localparam int SQ_W   = 2 * VALUE_BITS - 1 + $clog2(MAX_SIDE_SAMPLES);
  localparam int MAG_W  = SUM_W;
  localparam int PROD_W = 2 * MAG_W;
  localparam int STEP_W = $clog2(PROD_W);
  localparam int SAT_W  = (SQ_W + 1 > SCORE_W) ? SQ_W + 1 : SCORE_W;

  // Result error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY    = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

  typedef struct packed {
    logic                       side;
    logic signed [TARGET_W-1:0] target_value;
    logic                       last;
  } sample_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [ERR_W-1:0]          error_code;
  } result_t;

endpackage

[design/regression_split_variance_score.sv]
// Variance-reduction split score: per-side accumulators and a bit-serial square/divide sequencer.
//
//   channel   direction  handshake                    payload
//   sample    in         sample_valid / sample_ready  rsvs_pkg::sample_t (side, target_value, last)
//   result    out        result_valid / result_ready  rsvs_pkg::result_t (score, error_code)
//
// Samples without last are taken one per cycle; each is registered and added into its side's
// count, sum and sum of squares in the following cycle.
// A sample with last closes the split: after it, the sequencer squares each side's sum with a
// shift-add unit and divides the square by the count with a restoring divider, rounding up,
// then subtracts it from the sum of squares and adds the result into the total. An error
// result skips this arithmetic and goes straight to the output state.
// sample_ready stays low from the last sample until the result is loaded into the output
// register; a stalled result holds the block in its output state until taken.
// rst is synchronous and clears all accumulators, the sequencer and the output valid.
module regression_split_variance_score (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  rsvs_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_ready,
  output rsvs_pkg::result_t result
);

  localparam int CNT_W  = rsvs_pkg::CNT_W;
  localparam int SUM_W  = rsvs_pkg::SUM_W;
  localparam int SQ_W   = rsvs_pkg::SQ_W;
  localparam int MAG_W  = rsvs_pkg::MAG_W;
  localparam int PROD_W = rsvs_pkg::PROD_W;
  localparam int STEP_W = rsvs_pkg::STEP_W;
  localparam int SAT_W  = rsvs_pkg::SAT_W;
  localparam int VB     = rsvs_pkg::VALUE_BITS;
  localparam int SCW    = rsvs_pkg::SCORE_W;

  localparam logic [CNT_W-1:0] SIDE_MAX    = CNT_W'(rsvs_pkg::MAX_SIDE_SAMPLES);
  localparam logic [SAT_W:0]   SCORE_LIMIT = (SAT_W + 1)'(1) << (SCW - 1);

  // One-hot sequencer states
  typedef enum logic [6:0] {
    ST_ACCUM   = 7'b0000001,  // stream samples into the accumulators
    ST_EVAL    = 7'b0000010,  // check errors, load the left side
    ST_SQUARE  = 7'b0000100,  // shift-add: sum * sum
    ST_DIVIDE  = 7'b0001000,  // restoring divide by the count
    ST_DEVIATE = 7'b0010000,  // sumsq - ceil(sum^2 / count)
    ST_ADD     = 7'b0100000,  // add into the total, move to the next side
    ST_OUTPUT  = 7'b1000000   // load the result register, clear for the next split
  } state_t;

  state_t state;
  state_t state_next;

  // Sample pipeline register
  logic                 pend_valid;
  logic                 pend_side;
  logic                 pend_last;
  logic signed [VB-1:0] pend_value;

  // Per-side accumulators
  logic [CNT_W-1:0]        left_count;
  logic [CNT_W-1:0]        right_count;
  logic signed [SUM_W-1:0] left_sum;
  logic signed [SUM_W-1:0] right_sum;
  logic [SQ_W-1:0]         left_square_sum;
  logic [SQ_W-1:0]         right_square_sum;
  logic                    overflow_seen;

  // Shared square/divide datapath
  logic                       sel;
  logic [STEP_W-1:0]          step;
  logic [PROD_W-1:0]          mcand;
  logic [MAG_W-1:0]           mplier;
  logic [PROD_W-1:0]          prod;
  logic [CNT_W-1:0]           rem;
  logic [SQ_W-1:0]            dev;
  logic [SAT_W-1:0]           total;
  logic [rsvs_pkg::ERR_W-1:0] err;

  // Combinational helpers
  logic [VB-1:0]           raw_value;
  logic [VB-1:0]           pend_mag;
  logic [2*VB-1:0]         pend_sq;
  logic                    side_full;
  logic [CNT_W-1:0]        div;
  logic [SQ_W-1:0]         sq_sel;
  logic [CNT_W+1:0]        trial;
  logic                    qbit;
  logic [PROD_W-1:0]       ceil_q;
  logic [PROD_W-1:0]       sq_ext;
  logic [SAT_W:0]          tot_sum;
  logic [SCW-1:0]          neg_total;
  logic                    accept;
  logic                    out_load;
  logic                    empty_side;

  function automatic logic [MAG_W-1:0] sum_mag(input logic signed [SUM_W-1:0] s);
    logic [MAG_W-1:0] m;
    m = s[SUM_W-1] ? MAG_W'(-s) : MAG_W'(s);
    return m;
  endfunction

  assign sample_ready = (state == ST_ACCUM) && !(pend_valid && pend_last);
  assign accept       = sample_valid && sample_ready;
  assign out_load     = (state == ST_OUTPUT) && (!result_valid || result_ready);
  assign empty_side   = (left_count == '0) || (right_count == '0);

  // Take the low VALUE_BITS of the target and sign-extend from their top bit
  assign raw_value = VB'($unsigned(sample.target_value));
  assign pend_mag  = pend_value[VB-1] ? VB'(-pend_value) : VB'(pend_value);
  assign pend_sq   = pend_mag * pend_mag;
  assign side_full = pend_side ? (right_count >= SIDE_MAX) : (left_count >= SIDE_MAX);

  assign div    = sel ? right_count : left_count;
  assign sq_sel = sel ? right_square_sum : left_square_sum;

  assign trial  = {1'b0, rem, prod[PROD_W-1]} - {2'b00, div};
  assign qbit   = !trial[CNT_W+1];
  assign ceil_q = prod + PROD_W'(rem != '0);
  assign sq_ext = PROD_W'(sq_sel);

  assign tot_sum   = (SAT_W + 1)'(total) + (SAT_W + 1)'(dev);
  assign neg_total = SCW'(0) - total[SCW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      ST_ACCUM: begin
        if (pend_valid && pend_last) begin
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (overflow_seen || empty_side) begin
          state_next = ST_OUTPUT;
        end else begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (step == STEP_W'(MAG_W - 1)) begin
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (step == STEP_W'(PROD_W - 1)) begin
          state_next = ST_DEVIATE;
        end
      end
      ST_DEVIATE: begin
        state_next = ST_ADD;
      end
      ST_ADD: begin
        state_next = sel ? ST_OUTPUT : ST_SQUARE;
      end
      ST_OUTPUT: begin
        if (out_load) begin
          state_next = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  // Control state and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_ACCUM;
      pend_valid       <= 1'b0;
      result_valid     <= 1'b0;
      left_count       <= '0;
      right_count      <= '0;
      left_sum         <= '0;
      right_sum        <= '0;
      left_square_sum  <= '0;
      right_square_sum <= '0;
      overflow_seen    <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= accept;

      // Accumulate the registered sample; drop it if its side is full
      if (state == ST_ACCUM && pend_valid) begin
        if (side_full) begin
          overflow_seen <= 1'b1;
        end else if (pend_side) begin
          right_count      <= right_count + CNT_W'(1);
          right_sum        <= right_sum + SUM_W'(pend_value);
          right_square_sum <= right_square_sum + SQ_W'(pend_sq);
        end else begin
          left_count      <= left_count + CNT_W'(1);
          left_sum        <= left_sum + SUM_W'(pend_value);
          left_square_sum <= left_square_sum + SQ_W'(pend_sq);
        end
      end

      // Hand off the result and clear for the next split
      if (out_load) begin
        result_valid     <= 1'b1;
        left_count       <= '0;
        right_count      <= '0;
        left_sum         <= '0;
        right_sum        <= '0;
        left_square_sum  <= '0;
        right_square_sum <= '0;
        overflow_seen    <= 1'b0;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload and shared datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      pend_side  <= sample.side;
      pend_last  <= sample.last;
      pend_value <= $signed(raw_value);
    end

    case (state)
      ST_EVAL: begin
        if (overflow_seen) begin
          err <= rsvs_pkg::ERR_OVERFLOW;
        end else if (empty_side) begin
          err <= rsvs_pkg::ERR_EMPTY;
        end else begin
          err <= rsvs_pkg::ERR_NONE;
        end
        total  <= '0;
        sel    <= 1'b0;
        step   <= '0;
        prod   <= '0;
        mcand  <= PROD_W'(sum_mag(left_sum));
        mplier <= sum_mag(left_sum);
      end
      ST_SQUARE: begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        rem    <= '0;
        if (step == STEP_W'(MAG_W - 1)) begin
          step <= '0;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
      ST_DIVIDE: begin
        if (qbit) begin
          rem <= trial[CNT_W-1:0];
        end else begin
          rem <= {rem[CNT_W-2:0], prod[PROD_W-1]};
        end
        prod <= {prod[PROD_W-2:0], qbit};
        step <= step + STEP_W'(1);
      end
      ST_DEVIATE: begin
        dev <= (sq_ext >= ceil_q) ? SQ_W'(sq_ext - ceil_q) : '0;
      end
      ST_ADD: begin
        total  <= (tot_sum > SCORE_LIMIT) ? SAT_W'(SCORE_LIMIT) : tot_sum[SAT_W-1:0];
        sel    <= 1'b1;
        step   <= '0;
        prod   <= '0;
        mcand  <= PROD_W'(sum_mag(right_sum));
        mplier <= sum_mag(right_sum);
      end
      ST_OUTPUT: begin
        if (out_load) begin
          result.error_code <= err;
          result.score      <= (err == rsvs_pkg::ERR_NONE) ? $signed(neg_total) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Checks
  a_err_zero_score: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error_code != rsvs_pkg::ERR_NONE |-> result.score == '0)
    else $error("error result carries a nonzero score");

  a_score_nonpos: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.score[SCW-1] || result.score == '0))
    else $error("score is positive");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    state != ST_ACCUM |-> !sample_ready)
    else $error("sample taken while the sequencer is busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    left_count <= SIDE_MAX && right_count <= SIDE_MAX)
    else $error("side count beyond its limit");

  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    out_load |=> left_count == '0 && right_count == '0 && !overflow_seen && result_valid)
    else $error("split not cleared when the result was loaded");

endmodule
